>>> src/sha_pkg.sv
// sha_pkg: shared types, constants and round functions for the sha-256 stream hasher
// used by sha_core and sha256_stream_hasher under src
`default_nettype none
package sha_pkg;
    typedef enum logic [1:0] {
        CMD_ABSORB        = 2'd0,
        CMD_ABSORB_FINISH = 2'd1,
        CMD_FINISH        = 2'd2,
        CMD_UNUSED        = 2'd3
    } cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PAD,
        ST_LOAD,
        ST_ROUND,
        ST_UPDATE,
        ST_EMIT
    } state_t;

    // compression core sequencer
    typedef enum logic [2:0] {
        C_IDLE, C_LOAD, C_ROUND, C_ADD
    } cstate_t;

    typedef struct packed {
        logic        start;
        logic        busy;
    } core_ctl_t;

    function automatic logic [31:0] round_k(input logic [5:0] idx);
        logic [31:0] k;
        case (idx)
            6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
            6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
            6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
            6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
            6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
            6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
            6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
            6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
            6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
            6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
            6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
            6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
            default: k = 32'hc67178f2;
        endcase
        return k;
    endfunction

    function automatic logic [31:0] init_word(input logic [2:0] idx);
        logic [31:0] h;
        case (idx)
            3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
            3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
            3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
            3'd6: h = 32'h1f83d9ab;
            default: h = 32'h5be0cd19;
        endcase
        return h;
    endfunction

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction
endpackage
`default_nettype wire

>>> src/sha_ram.sv
// sha_ram: generic single-port write, single-port read ram with registered read
// no dependencies
`default_nettype none
module sha_ram #(
    parameter int unsigned Width = 8,
    parameter int unsigned Depth = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(Depth)-1:0] wr_addr,
    input  wire logic [Width-1:0]         wr_data,
    input  wire logic [$clog2(Depth)-1:0] rd_addr,
    output logic      [Width-1:0]         rd_data
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule
`default_nettype wire

>>> src/sha_core.sv
// sha_core: one-round-per-cycle sha-256 compression over a 64-byte buffer
// depends on sha_pkg and sha_ram (block buffer and chaining words)
`default_nettype none
module sha_core (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire sha_pkg::core_ctl_t   ctl_in,
    output sha_pkg::core_ctl_t        ctl_out,
    // byte buffer write port from the intake side
    input  wire logic                 buf_we,
    input  wire logic [5:0]           buf_addr,
    input  wire logic [7:0]           buf_data,
    // chaining word readout and restart
    input  wire logic                 chain_restart,
    input  wire logic [2:0]           chain_rd_idx,
    output logic      [31:0]          chain_rd_word
);
    import sha_pkg::*;

    // buffer holds 16 words; intake writes one byte lane at a time via read-modify-write-free
    // byte rams, four lanes of 16 entries each
    logic [31:0] buf_rd;
    logic [3:0]  buf_rd_addr;
    genvar g;
    generate
        for (g = 0; g < 4; g++) begin : g_lane
            sha_ram #(.Width(8), .Depth(16)) u_lane (
                .aclk   (aclk),
                .wr_en  (buf_we && (buf_addr[1:0] == 2'(3 - g))),
                .wr_addr(buf_addr[5:2]),
                .wr_data(buf_data),
                .rd_addr(buf_rd_addr),
                .rd_data(buf_rd[8*g +: 8])
            );
        end
    endgenerate

    // chaining words in a ram, restart handled by a valid flag per entry
    logic        ch_we;
    logic [2:0]  ch_waddr;
    logic [31:0] ch_wdata;
    logic [2:0]  ch_raddr;
    logic [31:0] ch_rdata;
    logic [7:0]  ch_valid_reg;
    logic [7:0]  ch_valid_next;
    logic [2:0]  ch_raddr_q_reg;

    sha_ram #(.Width(32), .Depth(8)) u_chain (
        .aclk   (aclk),
        .wr_en  (ch_we),
        .wr_addr(ch_waddr),
        .wr_data(ch_wdata),
        .rd_addr(ch_raddr),
        .rd_data(ch_rdata)
    );

    logic [31:0] ch_word;
    assign ch_word = ch_valid_reg[ch_raddr_q_reg] ? ch_rdata : init_word(ch_raddr_q_reg);
    assign chain_rd_word = ch_word;

    cstate_t     cst_reg, cst_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic [31:0] v_reg [8];
    logic [31:0] v_next [8];
    logic [31:0] w_reg [16];
    logic [31:0] w_next [16];

    logic [31:0] wt, s0, s1, big0, big1, ch_f, maj, t1, t2;

    always_comb begin
        s0 = rotr(w_reg[1], 7) ^ rotr(w_reg[1], 18) ^ (w_reg[1] >> 3);
        s1 = rotr(w_reg[14], 17) ^ rotr(w_reg[14], 19) ^ (w_reg[14] >> 10);
        wt = (cnt_reg < 7'd16) ? w_reg[0] : (s1 + w_reg[9] + s0 + w_reg[0]);
        big1 = rotr(v_reg[4], 6) ^ rotr(v_reg[4], 11) ^ rotr(v_reg[4], 25);
        ch_f = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        t1 = v_reg[7] + big1 + ch_f + round_k(cnt_reg[5:0]) + wt;
        big0 = rotr(v_reg[0], 2) ^ rotr(v_reg[0], 13) ^ rotr(v_reg[0], 22);
        maj = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t2 = big0 + maj;
    end

    always_comb begin
        cst_next = cst_reg;
        cnt_next = cnt_reg;
        v_next = v_reg;
        w_next = w_reg;
        buf_rd_addr = cnt_reg[3:0];
        ch_raddr = chain_rd_idx;
        ch_we = 1'b0;
        ch_waddr = cnt_reg[2:0];
        ch_wdata = '0;
        ch_valid_next = ch_valid_reg;
        case (cst_reg)
            C_IDLE: begin
                if (ctl_in.start) begin
                    cst_next = C_LOAD;
                    cnt_next = '0;
                end
            end
            C_LOAD: begin
                // issue reads of buffer word and chain word, capture them in the following cycle
                buf_rd_addr = cnt_reg[3:0];
                ch_raddr = cnt_reg[2:0];
                if (cnt_reg != 7'd0) begin
                    for (int i = 0; i < 15; i++) w_next[i] = w_reg[i+1];
                    w_next[15] = buf_rd;
                    if (cnt_reg <= 7'd8) begin
                        for (int i = 0; i < 7; i++) v_next[i] = v_reg[i+1];
                        v_next[7] = ch_word;
                    end
                end
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg == 7'd16) begin
                    cst_next = C_ROUND;
                    cnt_next = '0;
                end
            end
            C_ROUND: begin
                for (int i = 0; i < 15; i++) w_next[i] = w_reg[i+1];
                w_next[15] = wt;
                v_next[7] = v_reg[6]; v_next[6] = v_reg[5]; v_next[5] = v_reg[4];
                v_next[4] = v_reg[3] + t1;
                v_next[3] = v_reg[2]; v_next[2] = v_reg[1]; v_next[1] = v_reg[0];
                v_next[0] = t1 + t2;
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg == 7'd63) begin
                    cst_next = C_ADD;
                    cnt_next = '0;
                end
            end
            C_ADD: begin
                // read chain word i, add in the following cycle and write back
                ch_raddr = cnt_reg[2:0];
                if (cnt_reg != 7'd0) begin
                    ch_we = 1'b1;
                    ch_waddr = 3'(cnt_reg - 7'd1);
                    ch_wdata = ch_word + v_reg[0];
                    ch_valid_next[ch_waddr] = 1'b1;
                    for (int i = 0; i < 7; i++) v_next[i] = v_reg[i+1];
                end
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg == 7'd8) begin
                    cst_next = C_IDLE;
                end
            end
            default: cst_next = C_IDLE;
        endcase
        if (chain_restart) begin
            ch_valid_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cst_reg <= C_IDLE;
            cnt_reg <= '0;
            ch_valid_reg <= '0;
        end else begin
            cst_reg <= cst_next;
            cnt_reg <= cnt_next;
            ch_valid_reg <= ch_valid_next;
        end
        v_reg <= v_next;
        w_reg <= w_next;
        ch_raddr_q_reg <= ch_raddr;
    end

    assign ctl_out.start = 1'b0;
    assign ctl_out.busy = (cst_reg != C_IDLE);

    property p_no_start_busy;
        @(posedge aclk) disable iff (!aresetn) ctl_in.start |-> cst_reg == C_IDLE;
    endproperty
    a_no_start_busy: assert property (p_no_start_busy) else $error("start while busy");

    a_round_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        cst_reg == C_ROUND |-> cnt_reg < 7'd64) else $error("round count overrun");

    a_add_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (cst_reg == C_ADD && cnt_reg == 7'd8) |=> cst_reg == C_IDLE)
        else $error("add pass did not end");
endmodule
`default_nettype wire

>>> src/sha256_stream_hasher.sv
// sha256_stream_hasher: top level, byte intake, padding sequencer and digest output
// depends on sha_pkg and sha_core
//
// usage:
//   s_axis: one request per message byte; s_axis_tdata[7:0] = data_byte,
//   s_axis_tuser[1:0] = command (0 absorb, 1 absorb then finish, 2 finish only,
//   3 ignored).
//   m_axis: eight digest words after a finish, tdata = {word_index, digest_word},
//   tlast on word 7.
//   bytes are taken one per cycle while the core is idle; a byte that fills
//   the 64-byte buffer starts the compression core, which loads the block and
//   chaining words, runs 64 rounds and updates the chaining words; no byte is
//   taken meanwhile. a finish pads one byte per cycle while the core is idle,
//   runs one or two compressions and then presents the words, one per cycle
//   while m_axis_tready is high. a stalled receiver holds the current word;
//   no new request is taken until all eight words have gone.
//   reset returns the chaining words to the initial values and the count to 0.
`default_nettype none
module sha256_stream_hasher (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // data_byte[7:0]
    input  wire logic [1:0]  s_axis_tuser,   // command[1:0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,   // digest_word[31:0], word_index[34:32], zero fill
    output logic             m_axis_tlast    // last_word
);
    import sha_pkg::*;

    state_t      st_reg, st_next;
    logic [60:0] total_reg, total_next;
    logic [63:0] bits_reg, bits_next;
    logic [3:0]  pcnt_reg, pcnt_next;   // padding phase: 0 = 0x80, then zeros, len bytes
    logic [2:0]  widx_reg, widx_next;
    logic        fin_reg, fin_next;

    core_ctl_t   ctl_to_core, ctl_from_core;
    logic        buf_we;
    logic [5:0]  buf_addr;
    logic [7:0]  buf_data;
    logic        restart;
    logic [31:0] chain_word;

    sha_core u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .ctl_in       (ctl_to_core),
        .ctl_out      (ctl_from_core),
        .buf_we       (buf_we),
        .buf_addr     (buf_addr),
        .buf_data     (buf_data),
        .chain_restart(restart),
        .chain_rd_idx (widx_next),
        .chain_rd_word(chain_word)
    );

    logic        s_fire;
    logic [1:0]  cmd;
    logic [60:0] total_inc;
    logic        fills;
    logic [7:0]  len_byte;

    assign s_fire = s_axis_tvalid && s_axis_tready;
    assign cmd = s_axis_tuser;
    assign total_inc = total_reg + 61'd1;
    assign fills = (total_reg[5:0] == 6'd63);
    assign len_byte = bits_reg[63:56];

    always_comb begin
        st_next = st_reg;
        total_next = total_reg;
        bits_next = bits_reg;
        pcnt_next = pcnt_reg;
        widx_next = widx_reg;
        fin_next = fin_reg;
        buf_we = 1'b0;
        buf_addr = total_reg[5:0];
        buf_data = s_axis_tdata;
        ctl_to_core.start = 1'b0;
        ctl_to_core.busy = 1'b0;
        restart = 1'b0;
        s_axis_tready = (st_reg == ST_IDLE) && !ctl_from_core.busy;
        case (st_reg)
            ST_IDLE: begin
                if (s_fire && cmd != CMD_UNUSED) begin
                    fin_next = (cmd != CMD_ABSORB);
                    if (cmd != CMD_FINISH) begin
                        buf_we = 1'b1;
                        total_next = total_inc;
                        ctl_to_core.start = fills;
                    end
                    if (cmd != CMD_ABSORB) begin
                        st_next = ST_PAD;
                        pcnt_next = '0;
                        bits_next = {total_next, 3'b000};
                    end
                end
            end
            ST_PAD: begin
                if (!ctl_from_core.busy) begin
                    buf_we = 1'b1;
                    total_next = total_inc;
                    ctl_to_core.start = fills;
                    if (pcnt_reg == 4'd0) begin
                        buf_data = 8'h80;
                        pcnt_next = 4'd1;
                        if (total_reg[5:0] == 6'd55) pcnt_next = 4'd2;
                    end else if (pcnt_reg == 4'd1) begin
                        buf_data = 8'h00;
                        if (total_reg[5:0] == 6'd55) pcnt_next = 4'd2;
                    end else begin
                        buf_data = len_byte;
                        bits_next = {bits_reg[55:0], 8'h00};
                        pcnt_next = pcnt_reg + 4'd1;
                        if (pcnt_reg == 4'd9) begin
                            st_next = ST_LOAD;
                        end
                    end
                end
            end
            ST_LOAD: begin
                // wait for the last compression, then prefetch word 0
                if (!ctl_from_core.busy && !ctl_to_core.start) begin
                    widx_next = '0;
                    st_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (m_axis_tready) begin
                    if (widx_reg == 3'd7) begin
                        st_next = ST_IDLE;
                        restart = 1'b1;
                        total_next = '0;
                        fin_next = 1'b0;
                    end else begin
                        widx_next = widx_reg + 3'd1;
                    end
                end
            end
            default: st_next = ST_IDLE;
        endcase
    end

    // read data arrives in the cycle after widx_next is presented
    logic emit_ok_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= ST_IDLE;
            total_reg <= '0;
            pcnt_reg <= '0;
            widx_reg <= '0;
            fin_reg <= 1'b0;
            emit_ok_reg <= 1'b0;
        end else begin
            st_reg <= st_next;
            total_reg <= total_next;
            pcnt_reg <= pcnt_next;
            widx_reg <= widx_next;
            fin_reg <= fin_next;
            emit_ok_reg <= (st_next == ST_EMIT);
        end
        bits_reg <= bits_next;
    end

    assign m_axis_tvalid = (st_reg == ST_EMIT) && emit_ok_reg;
    assign m_axis_tdata = {5'd0, widx_reg, chain_word};
    assign m_axis_tlast = (widx_reg == 3'd7);

    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tready |-> !m_axis_tvalid) else $error("input ready while emitting");
    a_emit_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> fin_reg) else $error("output without finish");
    a_last_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> st_reg == ST_IDLE)
        else $error("no return to idle after last word");
endmodule
`default_nettype wire

>>> tb/sv/sha256_stream_hasher_tb.sv
// sha256_stream_hasher_tb: self-checking testbench for the streaming sha-256 hasher
// predicts each digest with its own hash model and checks the eight output words
// depends on sha_pkg and sha256_stream_hasher
`timescale 1ns / 1ps
module sha256_stream_hasher_tb;
    import sha_pkg::*;

    localparam int IdleLimit = 20000;
    localparam int MsgCount = 7;

    typedef struct packed {
        cmd_t       command;
        logic [7:0] data_byte;
    } byte_req_t;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } digest_word_t;

    logic        aclk;
    logic        aresetn;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;
    logic        m_axis_tlast;

    sha256_stream_hasher dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
    );

    // hash model state
    logic [31:0] chain_h [8];
    logic [60:0] msg_len;
    logic [7:0]  blk_buf [64];

    byte_req_t    pending_reqs [$];
    digest_word_t digest_expect [$];
    int  mismatches;
    int  digests_seen;
    int  idle_cycles;
    bit  stim_done;
    bit  hold_for_drain;
    int  send_gap;
    int  recv_gap;

    function automatic logic [31:0] ror(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    task automatic restart_hash();
        chain_h[0] = 32'h6a09e667; chain_h[1] = 32'hbb67ae85;
        chain_h[2] = 32'h3c6ef372; chain_h[3] = 32'ha54ff53a;
        chain_h[4] = 32'h510e527f; chain_h[5] = 32'h9b05688c;
        chain_h[6] = 32'h1f83d9ab; chain_h[7] = 32'h5be0cd19;
        msg_len = '0;
    endtask

    task automatic compress_blk();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] s0, s1, t1, t2;
        logic [31:0] kk [64];
        kk = '{
            32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
            32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
            32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
            32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
            32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
            32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
            32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
            32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
            32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
            32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
            32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};
        for (int r = 0; r < 16; r++)
            w[r] = {blk_buf[4*r], blk_buf[4*r+1], blk_buf[4*r+2], blk_buf[4*r+3]};
        for (int r = 16; r < 64; r++) begin
            s0 = ror(w[r-15], 7) ^ ror(w[r-15], 18) ^ (w[r-15] >> 3);
            s1 = ror(w[r-2], 17) ^ ror(w[r-2], 19) ^ (w[r-2] >> 10);
            w[r] = s1 + w[r-7] + s0 + w[r-16];
        end
        for (int i = 0; i < 8; i++) v[i] = chain_h[i];
        for (int r = 0; r < 64; r++) begin
            t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
                 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + kk[r] + w[r];
            t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
                 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) chain_h[i] += v[i];
    endtask

    task automatic take_byte(input logic [7:0] b);
        blk_buf[msg_len[5:0]] = b;
        msg_len = msg_len + 61'd1;
        if (msg_len[5:0] == 6'd0) compress_blk();
    endtask

    task automatic predict_req(input byte_req_t req);
        logic [63:0] bits;
        if (req.command == CMD_UNUSED) return;
        if (req.command != CMD_FINISH) take_byte(req.data_byte);
        if (req.command == CMD_ABSORB) return;
        bits = {msg_len, 3'b000};
        take_byte(8'h80);
        while (msg_len[5:0] != 6'd56) take_byte(8'h00);
        for (int i = 7; i >= 0; i--) take_byte(bits[8*i +: 8]);
        for (int i = 0; i < 8; i++)
            digest_expect.push_back('{chain_h[i], 3'(i), i == 7});
        restart_hash();
    endtask

    task automatic queue_req(input cmd_t c, input logic [7:0] b);
        pending_reqs.push_back('{c, b});
    endtask

    // message of n bytes, ending with absorb-then-finish or a plain finish
    task automatic queue_message(input int n, input bit plain_end);
        for (int i = 0; i < n; i++) begin
            if (i == n - 1 && !plain_end) queue_req(CMD_ABSORB_FINISH, 8'($urandom));
            else queue_req(CMD_ABSORB, 8'($urandom));
        end
        if (plain_end || n == 0) queue_req(CMD_FINISH, 8'($urandom));
    endtask

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        int lens [6];
        aresetn = 1'b0;
        restart_hash();
        for (int i = 0; i < 64; i++) blk_buf[i] = '0;
        // directed: empty message, byte extremes, ignored command, finish forms
        queue_req(CMD_FINISH, 8'hff);
        queue_req(CMD_UNUSED, 8'h5a);
        queue_req(CMD_ABSORB, 8'h00);
        queue_req(CMD_UNUSED, 8'hff);
        queue_req(CMD_ABSORB_FINISH, 8'hff);
        queue_req(CMD_ABSORB, 8'haa);
        queue_req(CMD_ABSORB, 8'h55);
        queue_req(CMD_FINISH, 8'h00);
        queue_req(CMD_ABSORB_FINISH, 8'h80);
        queue_req(CMD_FINISH, 8'h01);
        // messages: lengths around the padding boundaries, short and random ones, random endings
        lens = '{55, 56, 64, 3, 0, 1};
        for (int m = 0; m < MsgCount; m++) begin
            if (m < 6) queue_message(lens[m], 1'($urandom_range(0, 1)));
            else queue_message($urandom_range(0, 12), 1'($urandom_range(0, 1)));
            if ($urandom_range(0, 3) == 0) queue_req(CMD_UNUSED, 8'($urandom));
        end
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
            s_axis_tuser <= '0;
            send_gap <= 0;
            hold_for_drain <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                predict_req(pending_reqs.pop_front());
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (hold_for_drain && digest_expect.size() != 0) begin
                    s_axis_tvalid <= 1'b0;
                end else if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_reqs.size() != 0) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser <= pending_reqs[0].command;
                    s_axis_tdata <= pending_reqs[0].data_byte;
                    send_gap <= pick_gap();
                    // near the end, wait for each digest to drain after a finish
                    hold_for_drain <= (pending_reqs.size() < 40) &&
                        (pending_reqs[0].command inside {CMD_ABSORB_FINISH, CMD_FINISH});
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor and receiver stalls
    always @(posedge aclk) begin
        digest_word_t got, want;
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
            recv_gap <= 0;
            mismatches <= 0;
            digests_seen <= 0;
            idle_cycles <= 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = '{m_axis_tdata[31:0], m_axis_tdata[34:32], m_axis_tlast};
                if (got.last) digests_seen <= digests_seen + 1;
                if (digest_expect.size() == 0) begin
                    if (mismatches < 10)
                        $display("unexpected digest word %h idx %0d", got.word, got.index);
                    mismatches <= mismatches + 1;
                end else begin
                    want = digest_expect.pop_front();
                    if (got != want) begin
                        if (mismatches < 10)
                            $display("digest mismatch: exp %h/%0d/%0b got %h/%0d/%0b",
                                     want.word, want.index, want.last,
                                     got.word, got.index, got.last);
                        mismatches <= mismatches + 1;
                    end
                end
            end
            if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                recv_gap <= pick_gap();
            end
        end
    end

    initial begin
        stim_done = 1'b0;
        @(posedge aresetn);
        while (!stim_done) begin
            @(posedge aclk);
            if (idle_cycles >= IdleLimit) begin
                $display("watchdog: no traffic for %0d cycles", IdleLimit);
                $display("status: fail");
                $finish;
            end
            if (pending_reqs.size() == 0 && !s_axis_tvalid && digest_expect.size() == 0)
                stim_done = 1'b1;
        end
        repeat (200) @(posedge aclk);
        $display("covered %0d digests: empty, boundary-length and random messages,",
                 digests_seen);
        $display("ignored commands and random stalls; %0d mismatches", mismatches);
        if (mismatches == 0 && digest_expect.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
